// ----- rtl/convex_hull_segment_clip_depth_top_macros.svh -----
// Assertion macros for the hull probe checker.
`ifndef CONVEX_HULL_SEGMENT_CLIP_DEPTH_TOP_MACROS_SVH
`define CONVEX_HULL_SEGMENT_CLIP_DEPTH_TOP_MACROS_SVH

// Same-cycle implication under active-low reset.
`define CHSCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hull probe check failed");

// Next-cycle implication under active-low reset.
`define CHSCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hull probe check failed");

`endif

// ----- rtl/chscd_pkg.sv -----
// Types and constants shared by the hull probe and its checker.
`timescale 1ns / 1ps
`default_nettype none
package chscd_pkg;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_APPEND  = 2'd1;
    localparam logic [1:0] OP_DEPTH   = 2'd2;
    localparam logic [1:0] OP_SEGMENT = 2'd3;

    localparam logic CFG_TOLERANCE = 1'b0;
    localparam logic CFG_MIN_USABLE = 1'b1;

    localparam logic [16:0] TOLERANCE_RESET  = 17'd3277;
    localparam logic [5:0]  MIN_USABLE_RESET = 6'd4;
    localparam logic [31:0] ANSWER_MAX       = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_MUL,
        ST_EVAL,
        ST_DIV,
        ST_CHK,
        ST_LEN,
        ST_SQRT,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/convex_hull_segment_clip_depth_top.sv -----
// Hull probe: plane table in a memory, point depth and clipped segment length.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Command channel: an item is taken when start is high and busy is low.
//   Opcode clear and append finish in the cycle they are taken; busy stays low.
//   Opcode depth and segment raise busy and produce one result on o_answer,
//   o_answer_kind and o_saturated, marked by o_valid for a single cycle.
//   The receiver cannot stall; o_valid rises as busy falls.
//   Configuration: i_cfg_we writes i_cfg_data to the register at i_cfg_idx
//   (0 surface tolerance, 1 fewest usable planes), with effect at once.
// Datapath
//   Planes sit in one synchronous memory read once per plane, then a shared
//   34x34 multiplier forms both dot products.
//   Depth: each plane is read, differenced against the query point,
//   multiplied, evaluated and checked. Segment: the same per plane, plus a
//   division for each plane that clips (one quotient bit a cycle), then the
//   axis lengths and the square root (one root bit a cycle).
//   An unusable hull answers without reading any plane.
// Reset
//   Empties the plane table and loads the register defaults; no clearing
//   pass runs over the memory.
module convex_hull_segment_clip_depth_top
    import chscd_pkg::*;
#(
    parameter int MAX_PLANES = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_opcode,
    input  wire logic signed [31:0] i_ax,
    input  wire logic signed [31:0] i_ay,
    input  wire logic signed [31:0] i_az,
    input  wire logic signed [31:0] i_bx,
    input  wire logic signed [31:0] i_by,
    input  wire logic signed [31:0] i_bz,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [16:0]        i_cfg_data,
    output logic                    o_valid,
    output logic [31:0]             o_answer,
    output logic                    o_answer_kind,
    output logic                    o_saturated
);

    localparam int IDX_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int CNT_W = $clog2(MAX_PLANES + 1);

    t_state r_state, n_state;

    logic [191:0] mem [MAX_PLANES];
    logic [191:0] r_rd;

    logic [16:0]      r_tol;
    logic [5:0]       r_min;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;
    logic [4:0]       r_step;

    logic signed [31:0] r_a [3];
    logic signed [32:0] r_dir [3];
    logic signed [32:0] r_d [3];
    logic               r_kind;

    logic signed [67:0] r_prod;
    logic signed [51:0] r_off, r_slope;
    logic [51:0]        r_best;
    logic               r_have;

    logic [31:0] r_lo;
    logic [32:0] r_hi;
    logic [32:0] r_f;
    logic [52:0] r_rem;
    logic [51:0] r_den;
    logic [31:0] r_q;
    logic        r_div_hi;

    logic [63:0] r_sum;
    logic        r_over;
    logic [63:0] r_sqn, r_res, r_bit;

    logic        r_valid;
    logic [31:0] r_ans;
    logic        r_sat;

    logic               w_accept, w_query, w_usable;
    logic signed [31:0] w_n [3];
    logic signed [31:0] w_p [3];
    logic [1:0]         w_axis;
    logic signed [33:0] w_opa, w_opb;
    logic signed [67:0] w_prod;
    logic signed [51:0] w_term;
    logic [32:0]        w_e;
    logic [32:0]        w_mag [3];
    logic               w_off_nn, w_off_pos, w_slope_zero, w_slope_pos;
    logic [51:0]        w_neg_off, w_abs_slope;
    logic [52:0]        w_rem_s;
    logic               w_ge;
    logic [52:0]        w_rem_n;
    logic [31:0]        w_q_n;
    logic [64:0]        w_ns;
    logic [64:0]        w_sq_try;
    logic               w_sq_ge;
    logic [63:0]        w_res_n;
    logic               w_last_plane;
    logic [31:0]        n_ans;
    logic               n_sat;

    assign w_accept = start && !busy;
    assign w_query  = (i_opcode == OP_DEPTH) || (i_opcode == OP_SEGMENT);
    assign w_usable = {{(32-CNT_W){1'b0}}, r_count} >= {26'd0, r_min};

    assign w_p[0] = r_rd[191:160];
    assign w_p[1] = r_rd[159:128];
    assign w_p[2] = r_rd[127:96];
    assign w_n[0] = r_rd[95:64];
    assign w_n[1] = r_rd[63:32];
    assign w_n[2] = r_rd[31:0];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_mag[k] = r_dir[k][32] ? 33'(-r_dir[k]) : 33'(r_dir[k]);
        end
    end

    // Shared multiplier: dot-product terms in ST_MUL, axis lengths and squares in ST_LEN.
    assign w_e = r_prod[64:32];
    always_comb begin
        w_axis = 2'd0;
        w_opa  = '0;
        w_opb  = '0;
        if (r_state == ST_MUL) begin
            w_axis = (r_step < 5'd3) ? r_step[1:0] : 2'(r_step - 5'd3);
            if (r_step < 5'd3) begin
                w_opa = 34'(r_d[w_axis]);
                w_opb = 34'(w_n[w_axis]);
            end else if (r_step < 5'd6) begin
                w_opa = 34'(r_dir[w_axis]);
                w_opb = 34'(w_n[w_axis]);
            end
        end else if (r_state == ST_LEN) begin
            w_axis = 2'(r_step >> 1);
            if (r_step[0]) begin
                w_opa = {1'b0, w_e};
                w_opb = {1'b0, w_e};
            end else if (r_step < 5'd6) begin
                w_opa = {1'b0, w_mag[w_axis]};
                w_opb = {1'b0, r_f};
            end
        end
    end
    assign w_prod = w_opa * w_opb;
    // Arithmetic shift floors the Q16.16 product.
    assign w_term = r_prod[67:16];

    assign w_off_nn     = !r_off[51];
    assign w_off_pos    = w_off_nn && (r_off != '0);
    assign w_slope_zero = (r_slope == '0);
    assign w_slope_pos  = !r_slope[51] && !w_slope_zero;
    assign w_neg_off    = 52'(-r_off);
    assign w_abs_slope  = r_slope[51] ? 52'(-r_slope) : 52'(r_slope);

    assign w_rem_s = {r_rem[51:0], 1'b0};
    assign w_ge    = w_rem_s >= {1'b0, r_den};
    assign w_rem_n = w_ge ? (w_rem_s - {1'b0, r_den}) : w_rem_s;
    assign w_q_n   = {r_q[30:0], w_ge};

    assign w_ns     = {1'b0, r_sum} + {1'b0, r_prod[63:0]};
    assign w_sq_try = {1'b0, r_res} + {1'b0, r_bit};
    assign w_sq_ge  = {1'b0, r_sqn} >= w_sq_try;
    assign w_res_n  = w_sq_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);

    assign w_last_plane = {{(32-IDX_W){1'b0}}, r_idx} + 32'd1
                          >= {{(32-CNT_W){1'b0}}, r_count};

    // Next state and the result captured on entry to ST_DONE.
    always_comb begin
        n_state = r_state;
        n_ans   = '0;
        n_sat   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_query) begin
                    if (!w_usable || (r_count == '0 && i_opcode == OP_DEPTH)) begin
                        n_state = ST_DONE;
                    end else if (r_count == '0) begin
                        n_state = ST_LEN;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: n_state = ST_DIFF;
            ST_DIFF: n_state = ST_MUL;
            ST_MUL: begin
                if (r_step == 5'd6) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!r_kind) begin
                    n_state = w_off_nn ? ST_DONE : ST_CHK;
                end else if (w_slope_zero) begin
                    n_state = w_off_nn ? ST_DONE : ST_CHK;
                end else if (w_slope_pos) begin
                    if (w_off_nn) begin
                        n_state = ST_DONE;
                    end else if (w_neg_off < r_slope[51:0]) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_CHK;
                    end
                end else if (w_off_pos) begin
                    n_state = (r_off[51:0] >= w_abs_slope) ? ST_DONE : ST_DIV;
                end else begin
                    n_state = ST_CHK;
                end
            end
            ST_DIV: begin
                if (r_step == 5'd31) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if ({1'b0, r_lo} >= r_hi) begin
                    n_state = ST_DONE;
                end else if (!w_last_plane) begin
                    n_state = ST_READ;
                end else if (r_kind) begin
                    n_state = ST_LEN;
                end else begin
                    n_state = ST_DONE;
                    if (r_best > 52'(ANSWER_MAX)) begin
                        n_ans = ANSWER_MAX;
                        n_sat = 1'b1;
                    end else begin
                        n_ans = r_best[31:0];
                    end
                end
            end
            ST_LEN: begin
                if (r_step == 5'd6) begin
                    if (r_over || w_ns[64]) begin
                        n_state = ST_DONE;
                        n_ans   = ANSWER_MAX;
                        n_sat   = 1'b1;
                    end else begin
                        n_state = ST_SQRT;
                    end
                end
            end
            ST_SQRT: begin
                if (r_bit[0]) begin
                    n_state = ST_DONE;
                    n_ans   = w_res_n[31:0];
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy          = (r_state != ST_IDLE);
        o_valid       = r_valid;
        o_answer      = r_ans;
        o_answer_kind = r_kind;
        o_saturated   = r_sat;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_tol   <= TOLERANCE_RESET;
            r_min   <= MIN_USABLE_RESET;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_DONE);
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TOLERANCE) begin
                    r_tol <= i_cfg_data;
                end else begin
                    r_min <= i_cfg_data[5:0];
                end
            end
            if (w_accept && i_opcode == OP_CLEAR) begin
                r_count <= '0;
            end else if (w_accept && i_opcode == OP_APPEND
                         && r_count < CNT_W'(MAX_PLANES)) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Plane memory: written on append, read one plane per visit to ST_READ.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_opcode == OP_APPEND && r_count < CNT_W'(MAX_PLANES)) begin
            mem[r_count[IDX_W-1:0]] <= {i_ax, i_ay, i_az, i_bx, i_by, i_bz};
        end
        if (r_state == ST_READ) begin
            r_rd <= mem[r_idx];
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_step <= (n_state != r_state) ? 5'd0 : r_step + 5'd1;
        if (r_state != ST_DONE && n_state == ST_DONE) begin
            r_ans <= n_ans;
            r_sat <= n_sat;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_query) begin
                    r_a[0]   <= i_ax;
                    r_a[1]   <= i_ay;
                    r_a[2]   <= i_az;
                    r_dir[0] <= 33'(i_bx) - 33'(i_ax);
                    r_dir[1] <= 33'(i_by) - 33'(i_ay);
                    r_dir[2] <= 33'(i_bz) - 33'(i_az);
                    r_kind   <= (i_opcode == OP_SEGMENT);
                    r_idx    <= '0;
                    r_lo     <= '0;
                    r_hi     <= 33'h1_0000_0000;
                    r_f      <= 33'h1_0000_0000;
                    r_have   <= 1'b0;
                    r_best   <= '0;
                    r_sum    <= '0;
                    r_over   <= 1'b0;
                end
            end
            ST_DIFF: begin
                for (int k = 0; k < 3; k++) begin
                    r_d[k] <= 33'(r_a[k]) - 33'(w_p[k]);
                end
                r_off   <= 52'(r_tol);
                r_slope <= '0;
            end
            ST_MUL: begin
                if (r_step >= 5'd1 && r_step <= 5'd3) begin
                    r_off <= r_off + w_term;
                end else if (r_step >= 5'd4) begin
                    r_slope <= r_slope + w_term;
                end
            end
            ST_EVAL: begin
                if (!r_kind && !w_off_nn && (!r_have || w_neg_off < r_best)) begin
                    r_best <= w_neg_off;
                    r_have <= 1'b1;
                end
                r_q <= '0;
                if (w_slope_pos) begin
                    r_rem    <= {1'b0, w_neg_off};
                    r_den    <= r_slope[51:0];
                    r_div_hi <= 1'b1;
                end else begin
                    r_rem    <= {1'b0, r_off[51:0]};
                    r_den    <= w_abs_slope;
                    r_div_hi <= 1'b0;
                end
            end
            ST_DIV: begin
                r_rem <= w_rem_n;
                r_q   <= w_q_n;
                if (r_step == 5'd31) begin
                    if (r_div_hi && {1'b0, w_q_n} < r_hi) begin
                        r_hi <= {1'b0, w_q_n};
                    end
                    if (!r_div_hi && w_q_n > r_lo) begin
                        r_lo <= w_q_n;
                    end
                end
            end
            ST_CHK: begin
                r_idx <= r_idx + 1'b1;
                r_f   <= r_hi - {1'b0, r_lo};
            end
            ST_LEN: begin
                // Squares wrap at 64 bits; only the running sum flags overflow.
                if (r_step == 5'd2 || r_step == 5'd4 || r_step == 5'd6) begin
                    r_sum  <= w_ns[63:0];
                    r_over <= r_over | w_ns[64];
                end
                if (r_step == 5'd6) begin
                    r_sqn <= w_ns[63:0];
                    r_res <= '0;
                    r_bit <= 64'h4000_0000_0000_0000;
                end
            end
            ST_SQRT: begin
                if (w_sq_ge) begin
                    r_sqn <= r_sqn - w_sq_try[63:0];
                end
                r_res <= w_res_n;
                r_bit <= r_bit >> 2;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/chscd_checker.sv -----
// Port-level checker for the hull probe, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "convex_hull_segment_clip_depth_top_macros.svh"
module chscd_checker
    import chscd_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  i_opcode,
    input wire logic        o_valid,
    input wire logic [31:0] o_answer,
    input wire logic        o_saturated
);

    logic w_query_take;
    logic w_table_take;

    assign w_query_take = start && !busy && (i_opcode == OP_DEPTH || i_opcode == OP_SEGMENT);
    assign w_table_take = start && !busy && (i_opcode == OP_CLEAR || i_opcode == OP_APPEND);

    `CHSCD_ASSERT_NXT(a_query_busy, i_clk, i_rst_n, w_query_take, busy)
    `CHSCD_ASSERT_NXT(a_table_idle, i_clk, i_rst_n, w_table_take, !busy)
    `CHSCD_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    `CHSCD_ASSERT_NXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    `CHSCD_ASSERT_IMP(a_sat_max, i_clk, i_rst_n, o_valid && o_saturated, o_answer == ANSWER_MAX)

endmodule

bind convex_hull_segment_clip_depth_top chscd_checker u_chscd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_opcode    (i_opcode),
    .o_valid     (o_valid),
    .o_answer    (o_answer),
    .o_saturated (o_saturated)
);
`default_nettype wire
